// ===== sv/rrps_pkg.sv =====
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared constants and types of the round-robin process scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrps_pkg;

  // Process table size, a fixed index width and derived widths
  localparam int NUM_PROCS = 6;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int MODE_W    = 2;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_PROCS - 1);
  localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(NUM_PROCS - 1);
  localparam logic [IDX_W:0]   PROC_LIMIT = (IDX_W + 1)'(NUM_PROCS);

  // What the scan of the current event looks for
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,   // ignored event: report status only
    EV_SCHED   = 2'd1,   // find next ready process after current
    EV_UNBLOCK = 2'd2    // find lowest-index blocked process
  } ev_kind_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;   // capture event, apply io block, arm scan
    logic step;     // advance scan pointer
    logic commit;   // act on the process under the scan pointer
    logic emit;     // register result and pulse done
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    ev_kind_t kind;
    logic     hit;    // entry under the pointer matches the scan target
    logic     last;   // pointer is on the final candidate
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/rrps_datapath.sv =====
// ----------------------------------------------------------------------------
// rrps_datapath
// Process state table, current process, scan pointer and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rrps_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  rrps_pkg::dp_cmd_t           cmd,
  output rrps_pkg::dp_sts_t           sts,
  input  logic [rrps_pkg::MODE_W-1:0] mode,
  input  logic [rrps_pkg::IDX_W-1:0]  proc_index,
  output logic                        done,
  output logic                        stop_valid,
  output logic [rrps_pkg::IDX_W-1:0]  stop_index,
  output logic                        start_valid,
  output logic [rrps_pkg::IDX_W-1:0]  start_index,
  output logic                        idle,
  output logic [rrps_pkg::IDX_W-1:0]  current_index
);
  import rrps_pkg::*;

  typedef enum logic [1:0] {
    PS_READY   = 2'd0,
    PS_RUNNING = 2'd1,
    PS_BLOCKED = 2'd2
  } proc_state_t;

  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IO_DONE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IO_REQ  = 2'd2;

  proc_state_t      proc_state [NUM_PROCS];
  logic [IDX_W-1:0] current;
  logic             cur_running;   // proc_state[current] == PS_RUNNING
  ev_kind_t         kind;
  logic [IDX_W-1:0] ptr;
  logic [CNT_W-1:0] cnt;
  logic             stop_v;
  logic [IDX_W-1:0] stop_i;
  logic             start_v;
  logic [IDX_W-1:0] start_i;

  ev_kind_t         kind_in;
  logic             req_ok;
  logic [IDX_W-1:0] after_cur;
  logic [IDX_W-1:0] ptr_inc;
  proc_state_t      target;

  // Event decode
  assign req_ok = ({1'b0, proc_index} < PROC_LIMIT);

  always_comb begin
    case (mode)
      MODE_TICK:    kind_in = EV_SCHED;
      MODE_IO_DONE: kind_in = EV_UNBLOCK;
      MODE_IO_REQ:  kind_in = req_ok ? EV_SCHED : EV_NONE;
      default:      kind_in = EV_NONE;
    endcase
  end

  // Circular successors
  assign after_cur = (current == LAST_IDX) ? '0 : current + 1'b1;
  assign ptr_inc   = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;

  // Scan compare
  assign target   = (kind == EV_UNBLOCK) ? PS_BLOCKED : PS_READY;
  assign sts.kind = kind;
  assign sts.hit  = (proc_state[ptr] == target);
  assign sts.last = (cnt == LAST_CNT);

  // Control state: process table, current process, event kind, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      // process 0 runs, all others wait in ready
      for (int i = 0; i < NUM_PROCS; i++) begin
        proc_state[i] <= (i == 0) ? PS_RUNNING : PS_READY;
      end
      current       <= '0;
      cur_running   <= 1'b1;
      kind          <= EV_NONE;
      done          <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.accept) begin
        kind <= kind_in;
        if (mode == MODE_IO_REQ && req_ok) begin
          proc_state[proc_index] <= PS_BLOCKED;
          if (proc_index == current) begin
            cur_running <= 1'b0;
          end
        end
      end
      if (cmd.commit) begin
        if (kind == EV_UNBLOCK) begin
          proc_state[ptr] <= PS_READY;
        end else begin
          if (cur_running) begin
            proc_state[current] <= PS_READY;
          end
          proc_state[ptr] <= PS_RUNNING;
          current         <= ptr;
          cur_running     <= 1'b1;
        end
      end
    end
  end

  // Scan pointer, pending result and output registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ptr     <= (kind_in == EV_UNBLOCK) ? '0 : after_cur;
      cnt     <= '0;
      stop_v  <= 1'b0;
      stop_i  <= '0;
      start_v <= 1'b0;
      start_i <= '0;
    end
    if (cmd.step) begin
      ptr <= ptr_inc;
      cnt <= cnt + 1'b1;
    end
    if (cmd.commit && kind == EV_SCHED) begin
      if (cur_running) begin
        stop_v <= 1'b1;
        stop_i <= current;
      end
      start_v <= 1'b1;
      start_i <= ptr;
    end
    if (cmd.emit) begin
      stop_valid    <= stop_v;
      stop_index    <= stop_i;
      start_valid   <= start_v;
      start_index   <= start_i;
      idle          <= ~cur_running;
      current_index <= current;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rrps_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrps_ctrl
// Sequencer: accepts an event, steps the table scan, commits and reports.
// ----------------------------------------------------------------------------
`default_nettype none

module rrps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rrps_pkg::dp_sts_t sts,
  output rrps_pkg::dp_cmd_t cmd
);
  import rrps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.kind == EV_NONE) begin
          state_next = S_DONE;
        end else if (sts.hit) begin
          cmd.commit = 1'b1;
          state_next = S_DONE;
        end else if (sts.last) begin
          state_next = S_DONE;   // nothing found: no change
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ===== sv/round_robin_process_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_process_scheduler
// Round-robin scheduler over a small process table with io blocking.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+--------------------------------------
//  event    | start, busy            | mode, proc_index
//  result   | done (one-cycle pulse) | stop_valid, stop_index, start_valid,
//           |                        | start_index, idle, current_index
//
//  An event is taken when start is high and busy is low. The sequencer then
//  walks the process table one entry per cycle (up to NUM_PROCS entries,
//  stopping at a match), then registers the result and pulses done. busy
//  drops the cycle done is shown, so the next event may be taken then. rst is
//  synchronous and puts process 0 in running, the others in ready. Results
//  are not held off.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_process_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rrps_pkg::MODE_W-1:0] mode,
  input  logic [rrps_pkg::IDX_W-1:0]  proc_index,
  output logic                        done,
  output logic                        stop_valid,
  output logic [rrps_pkg::IDX_W-1:0]  stop_index,
  output logic                        start_valid,
  output logic [rrps_pkg::IDX_W-1:0]  start_index,
  output logic                        idle,
  output logic [rrps_pkg::IDX_W-1:0]  current_index
);
  import rrps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  rrps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Process table and result path
  rrps_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .proc_index    (proc_index),
    .done          (done),
    .stop_valid    (stop_valid),
    .stop_index    (stop_index),
    .start_valid   (start_valid),
    .start_index   (start_index),
    .idle          (idle),
    .current_index (current_index)
  );

endmodule

`default_nettype wire

// ===== sv/rrps_checker.sv =====
// ----------------------------------------------------------------------------
// rrps_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rrps_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       stop_valid,
  input logic [rrps_pkg::IDX_W-1:0] stop_index,
  input logic                       start_valid,
  input logic [rrps_pkg::IDX_W-1:0] start_index,
  input logic                       idle,
  input logic [rrps_pkg::IDX_W-1:0] current_index
);

  // An accepted event keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("event transfer did not raise busy");

  // A result appears only once the block has finished
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // A dispatch makes the started process current and running
  a_start_current: assert property (@(posedge clk) disable iff (rst)
    done && start_valid |-> !idle && current_index == start_index)
    else $error("dispatched process is not current");

  // A preemption always comes with a dispatch of a different process
  a_stop_needs_start: assert property (@(posedge clk) disable iff (rst)
    done && stop_valid |-> start_valid && stop_index != start_index)
    else $error("preemption without a matching dispatch");

endmodule

bind round_robin_process_scheduler rrps_checker u_rrps_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .stop_valid    (stop_valid),
  .stop_index    (stop_index),
  .start_valid   (start_valid),
  .start_index   (start_index),
  .idle          (idle),
  .current_index (current_index)
);

`default_nettype wire
